@@ rtl/tccs_pkg.sv @@
// Shared types and constants for the text console with cursor and scroll.
// Used by the sequencer and the top level; no dependencies.
`default_nettype none

package tccs_pkg;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ADDR_IN_W  = 11;
    localparam int CELL_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;

    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FLUSH,
        ST_BLANK,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 scrolled;
        logic [POS_OUT_W-1:0] cursor_pos;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [CELL_W-1:0]    cell_value;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/text_console_cursor_scroll_top.sv @@
// Top level of the text console: attribute register, result register and
// stream ports. Depends on tccs_pkg, tccs_ctrl and tccs_ram.
`default_nettype none

// A ROWS x COLS text store of 16-bit cells (attribute high, character low)
// with a cursor. After reset the block sweeps the store to spaces in
// attribute 0x0F, one cell per cycle, and takes no item until all ROWS*COLS
// cells are written; attribute writes are taken during that time. Each item
// then occupies the sequencer, which writes at most one cell of the
// single-port-write store per cycle; a clear, and a put that scrolls, keep it
// busy longest, since every cell is rewritten through the one write port.
// One finished result may wait in the output register while the next item
// is taken.
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,     // text_attribute
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // ch[7:0], cell_address[18:8], zero
    input  wire logic [1:0]  s_tuser,       // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata        // cell_value[15:0], cursor_row[20:16],
                                            // cursor_col[27:21], cursor_pos[38:28],
                                            // scrolled[39]
);

    localparam int CELLS = ROWS * COLS;
    localparam int LIN_W = $clog2(CELLS);

    logic [CHAR_W-1:0] attr_reg;
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;

    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic              ram_wr_en;
    logic [LIN_W-1:0]  ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [LIN_W-1:0]  ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    tccs_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .attr        (attr_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (op_t'(s_tuser)),
        .in_ch       (s_tdata[7:0]),
        .in_addr     (s_tdata[18:8]),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg     <= ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {res.scrolled, res.cursor_pos, res.cursor_col,
                            res.cursor_row, res.cell_value};
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccs_ctrl.sv @@
// Sequencer for the console: cursor registers, sweep counter with its address
// adder, and the cell store access pattern. Depends on tccs_pkg.
`default_nettype none

module tccs_ctrl
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [CHAR_W-1:0]                  attr,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire op_t                                in_op,
    input  wire logic [CHAR_W-1:0]                  in_ch,
    input  wire logic [ADDR_IN_W-1:0]               in_addr,
    output logic                                    ram_wr_en,
    output logic      [$clog2(ROWS*COLS)-1:0]       ram_wr_addr,
    output logic      [CELL_W-1:0]                  ram_wr_data,
    output logic                                    ram_rd_en,
    output logic      [$clog2(ROWS*COLS)-1:0]       ram_rd_addr,
    input  wire logic [CELL_W-1:0]                  ram_rd_data,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output res_t                                    res
);

    localparam int CELLS = ROWS * COLS;
    localparam int LIN_W = $clog2(CELLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam logic [LIN_W-1:0] LIN_COLS   = LIN_W'(COLS);
    localparam logic [LIN_W-1:0] LIN_LAST   = LIN_W'(CELLS - 1);
    localparam logic [LIN_W-1:0] COPY_LAST  = LIN_W'(CELLS - COLS - 1);
    localparam logic [LIN_W-1:0] BLANK_BASE = LIN_W'(CELLS - COLS);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLS - 1);

    state_t             state_reg, state_next;
    logic [LIN_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [LIN_W-1:0]   wa_reg, wa_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [LIN_W-1:0]   base_reg, base_next;
    logic               scr_reg, scr_next;
    logic [CELL_W-1:0]  val_reg, val_next;
    logic [CELL_W-1:0]  fill_reg, fill_next;

    logic               accept;
    logic               in_range;
    logic               is_lf;
    logic               is_cr;
    logic               wraps;
    logic               at_bottom;
    logic [LIN_W-1:0]   cur_lin;
    logic [LIN_W-1:0]   src_lin;

    assign accept    = in_valid && in_ready;
    assign in_range  = 32'(in_addr) < 32'(CELLS);
    assign is_lf     = in_ch == CH_LF;
    assign is_cr     = in_ch == CH_CR;
    assign wraps     = col_reg == COL_LAST;
    assign at_bottom = row_reg == ROW_LAST;
    assign cur_lin   = base_reg + LIN_W'(col_reg);
    assign src_lin   = cnt_reg + LIN_COLS;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (cnt_reg == LIN_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_op)
                        OP_PUT: begin
                            if (is_cr) begin
                                state_next = ST_DONE;
                            end else if ((is_lf || wraps) && at_bottom) begin
                                state_next = ST_SCROLL;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_CLEAR: state_next = ST_FILL;
                        OP_READ:  state_next = in_range ? ST_READ : ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_SCROLL: begin
                if (cnt_reg == COPY_LAST) state_next = ST_FLUSH;
            end
            ST_FLUSH:  state_next = ST_BLANK;
            ST_BLANK: begin
                if (cnt_reg == LIN_LAST) state_next = ST_DONE;
            end
            ST_FILL: begin
                if (cnt_reg == LIN_LAST) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) state_next = ST_IDLE;
            end
            default:   state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cnt_next    = cnt_reg;
        pend_next   = state_reg == ST_SCROLL;
        wa_next     = cnt_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        scr_next    = scr_reg;
        val_next    = val_reg;
        fill_next   = fill_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg;
        ram_wr_data = fill_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = LIN_W'(in_addr);

        unique case (state_reg)
            ST_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = CELL_RESET;
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    scr_next = 1'b0;
                    val_next = '0;
                    cnt_next = '0;
                    unique case (in_op)
                        OP_PUT: begin
                            if (is_cr) begin
                                col_next = '0;
                            end else begin
                                if (!is_lf) begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = cur_lin;
                                    ram_wr_data = {attr, in_ch};
                                    col_next    = col_reg + 1'b1;
                                end
                                if (is_lf || wraps) begin
                                    col_next = '0;
                                    if (at_bottom) begin
                                        scr_next = 1'b1;
                                    end else begin
                                        row_next  = row_reg + 1'b1;
                                        base_next = base_reg + LIN_COLS;
                                    end
                                end
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = {attr, in_ch};
                            row_next  = '0;
                            col_next  = '0;
                            base_next = '0;
                        end
                        OP_READ: begin
                            ram_rd_en = in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                val_next = ram_rd_data;
            end
            ST_SCROLL: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = src_lin;
                ram_wr_en   = pend_reg;
                ram_wr_addr = wa_reg;
                ram_wr_data = ram_rd_data;
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_FLUSH: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wa_reg;
                ram_wr_data = ram_rd_data;
                cnt_next    = BLANK_BASE;
            end
            ST_BLANK: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {attr, CH_SPACE};
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_FILL: begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.cell_value = val_reg;
        res.cursor_row = ROW_OUT_W'(row_reg);
        res.cursor_col = COL_OUT_W'(col_reg);
        res.cursor_pos = POS_OUT_W'(cur_lin);
        res.scrolled   = scr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            scr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            scr_reg   <= scr_next;
        end
    end

    always_ff @(posedge aclk) begin
        wa_reg   <= wa_next;
        val_reg  <= val_next;
        fill_reg <= fill_next;
    end

endmodule

`default_nettype wire

@@ rtl/tccs_checker.sv @@
// Port-level checks for the text console top level, attached by bind.
// Depends on text_console_cursor_scroll_top.
`default_nettype none

module tccs_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item still in work");

    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39]) |->
            (m_tdata[27:21] == 7'd0 && m_tdata[20:16] == 5'(ROWS - 1)))
        else $error("scroll reported with cursor off the start of the last row");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[20:16]) < 32'(ROWS) &&
                      32'(m_tdata[27:21]) < 32'(COLS)))
        else $error("cursor outside the screen");

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tccs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/text_console_cursor_scroll_top_test.sv @@
// Self-checking bench for text_console_cursor_scroll_top: a queue-fed stream driver,
// a result monitor and a cycle-free model of the 80 x 25 cell store and cursor.
// Depends on tccs_pkg and the RTL of the console.
`timescale 1ns / 1ps

module text_console_cursor_scroll_top_test;
    import tccs_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned DRAIN_LIMIT  = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 2100;
    localparam int unsigned PHASE_ITEMS  = 200;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    ch;
        logic [ADDR_IN_W-1:0] addr;
    } console_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'h0;
    logic [1:0]  s_tuser   = 2'b00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;

    text_console_cursor_scroll_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    logic [CELL_W-1:0] shadow_cells [0:CELLS-1];
    int                row_at;
    int                col_at;
    logic [7:0]        attr_byte;

    console_item_t pending_items [$];
    res_t          predicted_results [$];

    int unsigned items_queued  = 0;
    int unsigned results_done  = 0;
    int unsigned error_count   = 0;
    int unsigned scroll_count  = 0;
    int unsigned clear_count   = 0;
    int unsigned read_count    = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    bit          steady        = 1'b0;
    bit          item_taken    = 1'b0;
    logic        valid_next;
    logic        ready_next;
    console_item_t drive_item;
    res_t        got_result;
    res_t        want_result;

    function automatic int unsigned idle_len();
        int unsigned x;
        x = $urandom_range(0, 99);
        if (x < 55) return 0;
        if (x < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit line_down();
        if (row_at + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {attr_byte, CH_SPACE};
            row_at = ROWS - 1;
            scroll_count++;
            return 1'b1;
        end
        row_at++;
        return 1'b0;
    endfunction

    function automatic res_t next_console_result(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                                 logic [ADDR_IN_W-1:0] addr);
        res_t r;
        r = '0;
        if (op == OP_PUT) begin
            if (ch == CH_LF) begin
                col_at = 0;
                r.scrolled = line_down();
            end else if (ch == CH_CR) begin
                col_at = 0;
            end else begin
                shadow_cells[row_at * COLS + col_at] = {attr_byte, ch};
                col_at++;
                if (col_at >= COLS) begin
                    col_at = 0;
                    r.scrolled = line_down();
                end
            end
        end else if (op == OP_CLEAR) begin
            for (int i = 0; i < CELLS; i++) shadow_cells[i] = {attr_byte, ch};
            row_at = 0;
            col_at = 0;
            clear_count++;
        end else if (op == OP_READ) begin
            read_count++;
            if (addr < CELLS) r.cell_value = shadow_cells[addr];
        end
        r.cursor_row = ROW_OUT_W'(row_at);
        r.cursor_col = COL_OUT_W'(col_at);
        r.cursor_pos = POS_OUT_W'(row_at * COLS + col_at);
        return r;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("ERROR @%0t result %0d: %s", $realtime, results_done, msg);
    endtask

    task automatic compare_field(string name, int unsigned got, int unsigned want);
        if (got != want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic queue_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                              logic [ADDR_IN_W-1:0] addr);
        console_item_t it;
        it.op   = op;
        it.ch   = ch;
        it.addr = addr;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic drain_console();
        int unsigned waited;
        waited = 0;
        while (results_done != items_queued && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) flag_error("console stopped returning results");
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = items_queued;
        while (items_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(70, 95);
                repeat (len) queue_item(OP_PUT, 8'($urandom_range(0, 255)),
                                        11'($urandom_range(0, 2047)));
                len = $urandom_range(0, 9);
                if (len < 8) queue_item(OP_PUT, CH_LF, 11'($urandom_range(0, 2047)));
                else if (len < 9) queue_item(OP_PUT, CH_CR, 11'($urandom_range(0, 2047)));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_item(OP_READ, 8'($urandom_range(0, 255)),
                                   11'($urandom_range(CELLS, 2047)));
                    else
                        queue_item(OP_READ, 8'($urandom_range(0, 255)),
                                   11'($urandom_range(0, CELLS - 1)));
                end
            end else if (pick < 92) begin
                queue_item(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else if (pick < 94) begin
                queue_item(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end else begin
                repeat ($urandom_range(1, 5))
                    queue_item(OP_PUT, CH_LF, 11'($urandom_range(0, 2047)));
            end
        end
    endtask

    // hold the item until taken, then idle for the drawn gap
    always @(negedge aclk) begin
        valid_next = s_tvalid;
        if (!s_tvalid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                valid_next = 1'b0;
            end else if (pending_items.size() > 0) begin
                drive_item = pending_items.pop_front();
                s_tdata  <= {5'b0, drive_item.addr, drive_item.ch};
                s_tuser  <= drive_item.op;
                valid_next = 1'b1;
                gap_left = steady ? 0 : idle_len();
            end else begin
                valid_next = 1'b0;
            end
        end
        s_tvalid <= valid_next;
    end

    always @(negedge aclk) begin
        if (steady || stall_left == 0) begin
            ready_next = 1'b1;
            if (!steady && $urandom_range(0, 9) == 0) stall_left = idle_len();
        end else begin
            stall_left--;
            ready_next = 1'b0;
        end
        m_tready <= ready_next;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = m_tdata;
            if (predicted_results.size() == 0) begin
                flag_error($sformatf("result 0x%010h with no item waiting", m_tdata));
            end else begin
                want_result = predicted_results.pop_front();
                compare_field("cell_value", got_result.cell_value, want_result.cell_value);
                compare_field("cursor_row", got_result.cursor_row, want_result.cursor_row);
                compare_field("cursor_col", got_result.cursor_col, want_result.cursor_col);
                compare_field("cursor_pos", got_result.cursor_pos, want_result.cursor_pos);
                compare_field("scrolled", got_result.scrolled, want_result.scrolled);
                results_done++;
            end
        end
        item_taken = aresetn && s_tvalid && s_tready;
        if (item_taken)
            predicted_results.push_back(next_console_result(s_tuser, s_tdata[7:0],
                                                            s_tdata[18:8]));
    end

    initial begin : sequence_run
        logic [7:0] attr_plan [5];
        logic [7:0] attr_value;
        attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F};
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = CELL_RESET;
        row_at    = 0;
        col_at    = 0;
        attr_byte = ATTR_RESET;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'hFF, 11'd1999);
        queue_item(OP_READ, 8'h00, 11'd2000);
        queue_item(OP_READ, 8'h00, 11'h7FF);
        queue_item(OP_PUT, 8'h41, 11'h7FF);
        queue_item(OP_PUT, 8'h00, 11'd0);
        queue_item(OP_PUT, 8'hFF, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd1);
        queue_item(OP_READ, 8'h00, 11'd2);
        queue_item(OP_PUT, CH_CR, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_PUT, CH_LF, 11'd0);
        queue_item(OP_PUT, 8'h5A, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd80);
        queue_item(OP_UNUSED, 8'hFF, 11'h7FF);
        queue_item(OP_CLEAR, 8'hFF, 11'd0);
        queue_item(OP_READ, 8'h00, 11'd1999);
        queue_item(OP_CLEAR, 8'h00, 11'h7FF);
        queue_item(OP_READ, 8'h00, 11'd0);
        queue_item(OP_PUT, CH_LF, 11'd0);
        queue_item(OP_PUT, CH_CR, 11'd0);
        drain_console();

        for (int p = 0; p < 5; p++) begin
            attr_value = (p == 2) ? 8'($urandom_range(1, 254)) : attr_plan[p];
            cfg_we    <= 1'b1;
            cfg_wdata <= attr_value;
            attr_byte  = attr_value;
            @(negedge aclk);
            cfg_we    <= 1'b0;
            steady     = (p == 3);
            random_phase(PHASE_ITEMS);
            drain_console();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predicted_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", predicted_results.size()));
        $display("Run covered %0d items over six attribute settings:", items_queued);
        $display("  %0d scrolls, %0d clears, %0d reads", scroll_count, clear_count, read_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
